// ----- rtl/rspr_pkg.sv -----
// ============================================================================
// rspr_pkg
// Shared types, character codes and helpers of the packet receiver.
// ============================================================================
package rspr_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CHAR_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_LC_A   = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LC_F   = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_0      = 8'h30;  // '0'
    localparam logic [7:0] CHAR_9      = 8'h39;  // '9'
    localparam logic [7:0] CHAR_UC_A   = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UC_F   = 8'h46;  // 'F'
    localparam logic [7:0] HEX_TEN     = 8'd10;
    localparam logic [7:0] HEX_BAD     = 8'hFF;  // invalid digit, -1 in 8 bits

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BAD     = 3'd2,
        KIND_OVERRUN = 3'd3,
        KIND_RESTART = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] length;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_result;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            v = c - CHAR_LC_A + HEX_TEN;
        end else if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - CHAR_0;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            v = c - CHAR_UC_A + HEX_TEN;
        end
        return v;
    endfunction

endpackage

// ----- rtl/rspr_ifs.sv -----
// ============================================================================
// rspr channel interfaces
// Valid/ready channels for received bytes, results and the limit register.
// ============================================================================
interface rspr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rspr_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] length;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    modport source (output valid, output kind, output data, output length,
                    output computed_sum, output received_sum, input ready);
    modport sink   (input valid, input kind, input data, input length,
                    input computed_sum, input received_sum, output ready);
endinterface

interface rspr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_payload;
    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

// ----- rtl/rspr_framer.sv -----
// ============================================================================
// rspr_framer
// Packet state and per-byte deframing; forms at most one result per byte.
// ============================================================================
module rspr_framer
    import rspr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,       // consume i_byte this cycle
    input  logic [7:0] i_byte,
    input  logic [7:0] i_limit,
    output logic       o_res_valid,  // i_byte yields a result
    output t_result    o_res
);

    t_phase     r_phase,    n_phase;
    logic [7:0] r_sum,      n_sum;
    logic [7:0] r_count,    n_count;
    logic [7:0] r_hi_sum,   n_hi_sum;

    logic [7:0] w_sum_inc;
    logic [7:0] w_count_inc;
    logic [7:0] w_hex;
    logic [7:0] w_rsum;

    assign w_sum_inc   = r_sum + i_byte;
    assign w_count_inc = r_count + 8'd1;
    assign w_hex       = hex_value(i_byte);
    assign w_rsum      = r_hi_sum + w_hex;

    always_comb begin
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_count      = r_count;
        n_hi_sum     = r_hi_sum;
        o_res_valid  = 1'b0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.data         = 8'd0;
        o_res.length       = r_count;
        o_res.computed_sum = r_sum;
        o_res.received_sum = 8'd0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == CHAR_DOLLAR) begin
                    n_sum   = 8'd0;
                    n_count = 8'd0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_byte == CHAR_DOLLAR) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_RESTART;
                    n_sum       = 8'd0;
                    n_count     = 8'd0;
                end else if (i_byte == CHAR_HASH) begin
                    n_phase = PH_HI;
                end else begin
                    n_sum              = w_sum_inc;
                    n_count            = w_count_inc;
                    o_res_valid        = 1'b1;
                    o_res.length       = w_count_inc;
                    o_res.computed_sum = w_sum_inc;
                    if (w_count_inc >= i_limit) begin
                        o_res.kind = KIND_OVERRUN;
                        n_phase    = PH_HUNT;
                    end else begin
                        o_res.kind = KIND_PAYLOAD;
                        o_res.data = i_byte;
                    end
                end
            end
            PH_HI: begin
                n_hi_sum = {w_hex[3:0], 4'h0};
                n_phase  = PH_LO;
            end
            PH_LO: begin
                o_res_valid        = 1'b1;
                o_res.received_sum = w_rsum;
                if (w_rsum == r_sum) begin
                    o_res.kind = KIND_GOOD;
                    o_res.data = CHAR_PLUS;
                end else begin
                    o_res.kind = KIND_BAD;
                    o_res.data = CHAR_MINUS;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_sum    <= 8'd0;
            r_count  <= 8'd0;
            r_hi_sum <= 8'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_count  <= n_count;
            r_hi_sum <= n_hi_sum;
        end
    end

`ifndef SYNTH
    a_hash_to_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_BODY && i_byte == CHAR_HASH |=> r_phase == PH_HI)
        else $error("framer: '#' in body did not move to high digit");

    a_hi_to_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_HI |=> r_phase == PH_LO)
        else $error("framer: high digit did not move to low digit");

    a_good_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == KIND_GOOD |->
            o_res.received_sum == o_res.computed_sum)
        else $error("framer: good packet with mismatched checksum");

    a_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_phase == PH_BODY || r_phase == PH_LO)
        else $error("framer: result formed outside body or low digit");
`endif

endmodule

// ----- rtl/rspr_out_reg.sv -----
// ============================================================================
// rspr_out_reg
// Result register; holds one result until the downstream side takes it.
// ============================================================================
module rspr_out_reg
    import rspr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    rspr_res_if.source o_rsp
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.kind         = r_res.kind;
    assign o_rsp.data         = r_res.data;
    assign o_rsp.length       = r_res.length;
    assign o_rsp.computed_sum = r_res.computed_sum;
    assign o_rsp.received_sum = r_res.received_sum;

endmodule

// ----- rtl/rsp_packet_receiver.sv -----
// ============================================================================
// rsp_packet_receiver
// Deframes "$body#hh" packets from a byte stream, one byte per cycle while results are taken.
// ============================================================================
//
//  port     | dir | carries
//  ---------+-----+---------------------------------------------------------
//  i_rx     | in  | rx_byte, one received character per item
//  o_rsp    | out | kind, data, length, computed_sum, received_sum
//  i_cfg    | in  | max_payload, always ready
//
//  Two stages: an input register holds the accepted byte, the framer state
//  and its next-state logic sit between it and the result register.
//  One byte per cycle sustained while results are taken; a result is loaded
//  into the result register when its byte advances out of the input register.
//  A stalled result register holds the input register, which in turn drops
//  i_rx.ready; bytes that yield no result pass a stall freely.
//  Synchronous active-low reset clears state; max_payload resets to 255.
//
module rsp_packet_receiver
    import rspr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rspr_byte_if.sink  i_rx,
    rspr_cfg_if.sink   i_cfg,
    rspr_res_if.source o_rsp
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [7:0] r_max_payload;

    logic       w_fr_valid;
    t_result    w_fr_res;
    logic       w_out_free;
    logic       w_advance;
    logic       w_in_ready;

    // advance the held byte unless it makes a result that cannot be stored
    assign w_advance  = r_in_valid && (!w_fr_valid || w_out_free);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_rx.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg.valid) begin
            r_max_payload <= i_cfg.max_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    rspr_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_byte      (r_in_byte),
        .i_limit     (r_max_payload),
        .o_res_valid (w_fr_valid),
        .o_res       (w_fr_res)
    );

    rspr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_fr_valid),
        .i_res   (w_fr_res),
        .o_free  (w_out_free),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTH
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_fr_valid |=> o_rsp.valid)
        else $error("top: produced result not registered");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_ready |-> r_in_valid && w_fr_valid && !w_out_free)
        else $error("top: input stalled without a blocked result");

    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte))
        else $error("top: stalled byte lost or changed");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for rsp_packet_receiver. A clocked driver feeds
// received bytes from a queue. A clocked monitor takes results with random
// stalls and checks each one against a framing predictor that runs on every
// accepted byte. The body limit is rewritten between phases while the block
// is idle.
// ============================================================================
module tb_top;
    import rspr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 190;
    localparam int MAX_GAP      = 14;
    localparam int SHOW_LIMIT   = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 10;

    logic i_clk;
    logic i_rst_n;

    rspr_byte_if rx_ch ();
    rspr_cfg_if  cfg_ch ();
    rspr_res_if  rsp_ch ();

    rsp_packet_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    // Framer state as the predictor sees it
    t_phase     frame_phase;
    logic [7:0] frame_sum;
    logic [7:0] frame_len;
    logic [7:0] hi_digit_sum;
    logic [7:0] limit_reg;

    t_result    result_q [$];   // results still owed by the block
    logic [7:0] byte_q [$];     // bytes waiting for the driver

    int rx_wait     = 0;
    int rsp_wait    = 0;
    bit rx_calm     = 1'b0;
    bit rsp_calm    = 1'b0;
    int fail_count  = 0;
    int cycle_count = 0;
    int phase_items = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------

    // Decode one checksum character; anything that is not a hex digit
    // counts as all ones.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9)
            return c - CHAR_0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_F)
            return c - CHAR_UC_A + HEX_TEN;
        if (c >= CHAR_LC_A && c <= CHAR_LC_F)
            return c - CHAR_LC_A + HEX_TEN;
        return HEX_BAD;
    endfunction

    // Advance the framer by one accepted byte and queue the result it owes.
    function automatic void frame_byte(input logic [7:0] b);
        logic [7:0] rsum;
        case (frame_phase)
            PH_HUNT: begin
                // Ignore everything until a start character opens a body
                if (b == CHAR_DOLLAR) begin
                    frame_sum   = 8'h00;
                    frame_len   = 8'h00;
                    frame_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (b == CHAR_DOLLAR) begin
                    // Restart: report the body thrown away, then begin anew
                    result_q.push_back('{kind: KIND_RESTART, data: 8'h00,
                                         length: frame_len,
                                         computed_sum: frame_sum,
                                         received_sum: 8'h00});
                    frame_sum = 8'h00;
                    frame_len = 8'h00;
                end else if (b == CHAR_HASH) begin
                    frame_phase = PH_HI;
                end else begin
                    frame_sum = frame_sum + b;
                    frame_len = frame_len + 8'd1;
                    if (frame_len >= limit_reg) begin
                        // Overrun replaces the payload item of this byte
                        result_q.push_back('{kind: KIND_OVERRUN, data: 8'h00,
                                             length: frame_len,
                                             computed_sum: frame_sum,
                                             received_sum: 8'h00});
                        frame_phase = PH_HUNT;
                    end else begin
                        result_q.push_back('{kind: KIND_PAYLOAD, data: b,
                                             length: frame_len,
                                             computed_sum: frame_sum,
                                             received_sum: 8'h00});
                    end
                end
            end
            PH_HI: begin
                hi_digit_sum = digit_value(b) << 4;
                frame_phase  = PH_LO;
            end
            default: begin
                rsum = hi_digit_sum + digit_value(b);
                if (rsum == frame_sum)
                    result_q.push_back('{kind: KIND_GOOD, data: CHAR_PLUS,
                                         length: frame_len,
                                         computed_sum: frame_sum,
                                         received_sum: rsum});
                else
                    result_q.push_back('{kind: KIND_BAD, data: CHAR_MINUS,
                                         length: frame_len,
                                         computed_sum: frame_sum,
                                         received_sum: rsum});
                frame_phase = PH_HUNT;
            end
        endcase
    endfunction

    // Per-item wait of either side; flip now and then into a stretch of
    // back-to-back items.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued bytes, hold while the block stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'h00;
        end else begin
            // Run the predictor on the byte that moves at this edge
            if (rx_ch.valid && rx_ch.ready) begin
                frame_byte(rx_ch.rx_byte);
                rx_wait = draw_gap(rx_calm);
            end
            if (rx_ch.valid && !rx_ch.ready) begin
                // Hold the item until the block takes it
            end else if (rx_wait > 0) begin
                rx_ch.valid <= 1'b0;
                rx_wait--;
            end else if (byte_q.size() != 0) begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= byte_q.pop_front();
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: accept results with random stalls, check against the
    // oldest owed result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.kind         = t_kind'(rsp_ch.kind);
                got.data         = rsp_ch.data;
                got.length       = rsp_ch.length;
                got.computed_sum = rsp_ch.computed_sum;
                got.received_sum = rsp_ch.received_sum;
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("unexpected result: kind=%0d data=%h len=%0d csum=%h rsum=%h",
                                 got.kind, got.data, got.length, got.computed_sum,
                                 got.received_sum);
                end else begin
                    want = result_q.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.length !== want.length ||
                        got.computed_sum !== want.computed_sum ||
                        got.received_sum !== want.received_sum) begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT) begin
                            $display("mismatch: expected kind=%0d data=%h len=%0d csum=%h rsum=%h",
                                     want.kind, want.data, want.length,
                                     want.computed_sum, want.received_sum);
                            $display("          got      kind=%0d data=%h len=%0d csum=%h rsum=%h",
                                     got.kind, got.data, got.length,
                                     got.computed_sum, got.received_sum);
                        end
                    end
                end
                rsp_wait = draw_gap(rsp_calm);
            end
            if (rsp_wait > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_wait--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] b);
        byte_q.push_back(b);
        phase_items++;
    endtask

    // Checksum character for one nibble, letters in either case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CHAR_0 + n;
        return (($urandom_range(0, 1) != 0) ? CHAR_LC_A : CHAR_UC_A) + n - HEX_TEN;
    endfunction

    // One framed packet with a clean body; a bad checksum is either a
    // single flipped bit or two arbitrary bytes.
    task automatic push_packet(input int len, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        sum = 8'h00;
        push_char(CHAR_DOLLAR);
        for (k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            // Keep framing characters out of a well-formed body
            if (b == CHAR_DOLLAR || b == CHAR_HASH)
                b = b + 8'h40;
            sum = sum + b;
            push_char(b);
        end
        push_char(CHAR_HASH);
        if (good || $urandom_range(0, 1) != 0) begin
            if (!good)
                sum = sum ^ (8'h01 << $urandom_range(0, 7));
            push_char(hex_char(sum[7:4]));
            push_char(hex_char(sum[3:0]));
        end else begin
            push_char(8'($urandom_range(0, 255)));
            push_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Body lengths: around the limit when it is small, mostly short otherwise
    function automatic int pick_body_len();
        if (limit_reg <= 8'd40)
            return int'($urandom_range(0, int'(limit_reg) + 2));
        if ($urandom_range(0, 59) == 0)
            return int'(limit_reg) + 1;
        return int'($urandom_range(0, 24));
    endfunction

    // Wait until every byte is in and every owed result is out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || rx_ch.valid || result_q.size() != 0);
    endtask

    task automatic write_limit(input logic [7:0] v);
        @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.max_payload <= v;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_reg = v;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] limit_plan [NUM_PHASES];
        int         p;
        int         pick;

        // Drive every input to a known value before the first edge
        i_rst_n            = 1'b0;
        rx_ch.valid        = 1'b0;
        rx_ch.rx_byte      = 8'h00;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.max_payload = MAX_PAYLOAD_RESET;

        frame_phase  = PH_HUNT;
        frame_sum    = 8'h00;
        frame_len    = 8'h00;
        hi_digit_sum = 8'h00;
        limit_reg    = MAX_PAYLOAD_RESET;

        limit_plan[0] = 8'd255;
        limit_plan[1] = 8'd1;
        limit_plan[2] = 8'd0;
        limit_plan[3] = 8'd3;
        limit_plan[4] = 8'd254;
        limit_plan[5] = 8'($urandom_range(4, 40));
        limit_plan[6] = 8'd2;
        limit_plan[7] = 8'($urandom_range(1, 255));
        limit_plan[8] = 8'd16;
        limit_plan[9] = 8'd255;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset limit.
        // Noise while hunting, extremes of the byte range.
        push_char(8'h00);
        push_char(8'hFF);
        // Good packet: body 00 FF A0 sums to 9F, checksum digits at the top
        // of their ranges.
        push_char(CHAR_DOLLAR);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'hA0);
        push_char(CHAR_HASH);
        push_char(CHAR_9);
        push_char(CHAR_UC_F);
        // Restart inside a body, then two invalid digits, a start
        // character among them.
        push_char(CHAR_DOLLAR);
        push_char(CHAR_UC_A);
        push_char(CHAR_DOLLAR);
        push_char(8'h78);
        push_char(CHAR_HASH);
        push_char(8'h7A);
        push_char(CHAR_DOLLAR);
        // Empty body with checksum 00
        push_char(CHAR_DOLLAR);
        push_char(CHAR_HASH);
        push_char(CHAR_0);
        push_char(CHAR_0);
        // Hash taken as a high digit, lower-case low digit
        push_char(CHAR_DOLLAR);
        push_char(CHAR_HASH);
        push_char(CHAR_HASH);
        push_char(CHAR_LC_F);

        for (p = 0; p < NUM_PHASES; p++) begin
            // Change the limit only with nothing in flight
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            write_limit(limit_plan[p]);
            @(negedge i_clk);
            phase_items = 0;

            if (limit_plan[p] == 8'd3) begin
                // Overrun on the third body byte
                push_char(CHAR_DOLLAR);
                push_char(CHAR_LC_A);
                push_char(8'h62);
                push_char(8'h63);
            end
            if (limit_plan[p] == 8'd0) begin
                // Zero limit: the first body byte overruns at once
                push_char(CHAR_DOLLAR);
                push_char(8'h71);
            end
            if (p == 0)
                push_packet(256, 1'b1);  // overrun at the widest limit

            // Random part: mostly well-formed packets, some noise and
            // broken frames
            while (phase_items < PHASE_ITEMS) begin
                pick = int'($urandom_range(0, 19));
                if (pick < 15) begin
                    push_packet(pick_body_len(), $urandom_range(0, 3) != 0);
                end else if (pick < 17) begin
                    repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
                end else begin
                    push_char(CHAR_DOLLAR);
                    repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
                end
            end
        end

        // Drain, then give stray results a chance to show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (result_q.size() != 0) begin
            $display("%0d expected results never arrived", result_q.size());
            fail_count += result_q.size();
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
